@@ src/assert_macros.svh @@
// Concurrent assertion helpers; clk and rst come from the calling scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define FFCA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define FFCA_ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) cond |=> prop) else $error(msg);
`else
`define FFCA_ASSERT(lbl, prop, msg)
`define FFCA_ASSERT_NEXT(lbl, cond, prop, msg)
`endif
`endif

@@ src/ffca_pkg.sv @@
package ffca_pkg;

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_ERASE  = 2'd1,
    OP_DEFRAG = 2'd2,
    OP_NOP    = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    RS_OK            = 2'd0,
    RS_ALLOC_FAILED  = 2'd1,
    RS_ILLEGAL_ERASE = 2'd2
  } resp_code_t;

  localparam logic [7:0] CFG_RESET = 8'd128;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  request_size;
    logic [15:0] erase_handle;
  } req_t;

  typedef struct packed {
    resp_code_t  status;
    logic [15:0] new_handle;
  } rsp_t;

  typedef struct packed {
    logic start;
    logic scan;
    logic fill;
    logic zero;
    logic clear;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    opcode_t op;
    logic    clear_done;
    logic    scan_done;
    logic    found;
    logic    fill_done;
    logic    zero_done;
    logic    alloc_bad;
    logic    erase_bad;
    logic    out_free;
  } dp_sts_t;

endpackage

@@ src/ffca_chan_if.sv @@
interface ffca_chan_if #(
  parameter type word_t = logic
) ();
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ src/ffca_ctrl.sv @@
`include "assert_macros.svh"

module ffca_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  ffca_pkg::dp_sts_t sts,
  output ffca_pkg::dp_cmd_t cmd
);

  typedef enum logic [8:0] {
    ST_CLEAR       = 9'b000000001,
    ST_IDLE        = 9'b000000010,
    ST_DISPATCH    = 9'b000000100,
    ST_ALLOC_SCAN  = 9'b000001000,
    ST_ALLOC_FILL  = 9'b000010000,
    ST_ERASE_SCAN  = 9'b000100000,
    ST_DEFRAG_SCAN = 9'b001000000,
    ST_DEFRAG_ZERO = 9'b010000000,
    ST_DONE        = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (sts.clear_done) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_next = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        unique case (sts.op)
          ffca_pkg::OP_ALLOC:  state_next = ST_ALLOC_SCAN;
          ffca_pkg::OP_ERASE:  state_next = ST_ERASE_SCAN;
          ffca_pkg::OP_DEFRAG: state_next = ST_DEFRAG_SCAN;
          default:             state_next = ST_DONE;
        endcase
      end
      ST_ALLOC_SCAN: begin
        priority if (sts.found) state_next = ST_ALLOC_FILL;
        else if (sts.alloc_bad) state_next = ST_DONE;
        else if (sts.scan_done) state_next = ST_DONE;
        else state_next = ST_ALLOC_SCAN;
      end
      ST_ALLOC_FILL: begin
        if (sts.fill_done) state_next = ST_DONE;
      end
      ST_ERASE_SCAN: begin
        if (sts.erase_bad || sts.scan_done) state_next = ST_DONE;
      end
      ST_DEFRAG_SCAN: begin
        if (sts.scan_done) state_next = ST_DEFRAG_ZERO;
      end
      ST_DEFRAG_ZERO: begin
        if (sts.zero_done) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  assign in_ready   = (state == ST_IDLE);
  assign cmd.start  = in_ready && in_valid;
  assign cmd.scan   = (state == ST_ALLOC_SCAN) || (state == ST_ERASE_SCAN) ||
                      (state == ST_DEFRAG_SCAN);
  assign cmd.fill   = (state == ST_ALLOC_FILL);
  assign cmd.zero   = (state == ST_DEFRAG_ZERO);
  assign cmd.clear  = (state == ST_CLEAR);
  assign cmd.finish = (state == ST_DONE) && sts.out_free;

  `FFCA_ASSERT_NEXT(a_accept_dispatch, in_valid && in_ready, state == ST_DISPATCH, "accept did not dispatch")
  `FFCA_ASSERT(a_one_cmd, $onehot0({cmd.start, cmd.scan, cmd.fill, cmd.zero, cmd.clear, cmd.finish}), "overlapping commands")

endmodule

@@ src/ffca_datapath.sv @@
`include "assert_macros.svh"

module ffca_datapath #(
  parameter int CELLS       = 128,
  parameter int HANDLE_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_wdata,
  input  ffca_pkg::req_t    req_word,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output ffca_pkg::rsp_t    rsp_word,
  input  ffca_pkg::dp_cmd_t cmd,
  output ffca_pkg::dp_sts_t sts
);

  localparam int IDX_W = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int CNT_W = $clog2(CELLS + 1);
  localparam int LIM_W = (CNT_W > 8) ? CNT_W : 8;
  localparam int HW    = (HANDLE_BITS > 16) ? HANDLE_BITS : 16;

  logic [HANDLE_BITS-1:0] mem [CELLS];

  logic [7:0]             cells_in_use;
  logic [HANDLE_BITS-1:0] last_handle;
  ffca_pkg::opcode_t      req_op;
  logic [7:0]             req_size;
  logic [15:0]            req_handle;
  logic [CNT_W-1:0]       cnt;
  logic                   rd_vld;
  logic [IDX_W-1:0]       rd_idx;
  logic [HANDLE_BITS-1:0] rdata;
  logic [IDX_W-1:0]       run_start;
  logic [CNT_W-1:0]       run_len;
  logic [CNT_W-1:0]       wr;
  logic [CNT_W-1:0]       fill_end;
  logic                   found;
  logic                   out_valid;
  ffca_pkg::rsp_t         out_word;
  ffca_pkg::rsp_t         out_word_next;

  logic [LIM_W-1:0]       cfg_ext;
  logic [CNT_W-1:0]       lim;
  logic                   issue;
  logic                   proc_en;
  logic                   owner_free;
  logic                   alloc_bad;
  logic                   erase_bad;
  logic [IDX_W-1:0]       run_begin;
  logic                   run_fits;
  logic                   alloc_step;
  logic                   erase_hit;
  logic                   defrag_move;
  logic                   we;
  logic                   wr_adv;
  logic [IDX_W-1:0]       waddr;
  logic [HANDLE_BITS-1:0] wdata;

  assign cfg_ext = LIM_W'(cells_in_use);
  assign lim     = (cfg_ext < LIM_W'(CELLS)) ? CNT_W'(cfg_ext) : CNT_W'(CELLS);

  assign issue       = cmd.scan && (cnt != lim);
  assign proc_en     = cmd.scan && rd_vld;
  assign owner_free  = (rdata == '0);
  assign alloc_bad   = (req_size == 8'd0) || (&last_handle);
  assign erase_bad   = (req_handle == 16'd0) || (HW'(req_handle) > HW'(last_handle));
  assign run_begin   = (run_len == '0) ? rd_idx : run_start;
  assign run_fits    = (LIM_W'(run_len) + LIM_W'(1)) >= LIM_W'(req_size);
  assign alloc_step  = proc_en && (req_op == ffca_pkg::OP_ALLOC) && !alloc_bad && !found;
  assign erase_hit   = proc_en && (req_op == ffca_pkg::OP_ERASE) && !erase_bad &&
                       (HW'(rdata) == HW'(req_handle));
  assign defrag_move = proc_en && (req_op == ffca_pkg::OP_DEFRAG) && !owner_free;

  always_comb begin
    we     = 1'b0;
    wr_adv = 1'b0;
    waddr  = wr[IDX_W-1:0];
    wdata  = '0;
    priority if (cmd.clear) begin
      we     = (wr != CNT_W'(CELLS));
      wr_adv = we;
    end else if (cmd.fill) begin
      we     = (wr != fill_end);
      wr_adv = we;
      wdata  = last_handle;
    end else if (cmd.zero) begin
      we     = (wr != lim);
      wr_adv = we;
    end else if (erase_hit) begin
      we    = 1'b1;
      waddr = rd_idx;
    end else if (defrag_move) begin
      we     = 1'b1;
      wr_adv = 1'b1;
      wdata  = rdata;
    end else begin
      we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[cnt[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cells_in_use <= ffca_pkg::CFG_RESET;
      last_handle  <= '0;
      cnt          <= '0;
      rd_vld       <= 1'b0;
      run_len      <= '0;
      wr           <= '0;
      found        <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        cells_in_use <= cfg_wdata;
      end
      rd_vld <= issue;
      if (issue) begin
        cnt <= cnt + CNT_W'(1);
      end
      if (wr_adv) begin
        wr <= wr + CNT_W'(1);
      end
      if (alloc_step) begin
        if (owner_free) begin
          if (run_fits) begin
            found       <= 1'b1;
            wr          <= CNT_W'(run_begin);
            last_handle <= last_handle + HANDLE_BITS'(1);
          end else begin
            run_len <= run_len + CNT_W'(1);
          end
        end else begin
          run_len <= '0;
        end
      end
      if (erase_hit) begin
        found <= 1'b1;
      end
      if (cmd.start) begin
        cnt     <= '0;
        run_len <= '0;
        wr      <= '0;
        found   <= 1'b0;
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (rsp_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    out_word_next.status     = ffca_pkg::RS_OK;
    out_word_next.new_handle = '0;
    unique case (req_op)
      ffca_pkg::OP_ALLOC: begin
        out_word_next.status     = found ? ffca_pkg::RS_OK : ffca_pkg::RS_ALLOC_FAILED;
        out_word_next.new_handle = found ? 16'(HW'(last_handle)) : 16'd0;
      end
      ffca_pkg::OP_ERASE: begin
        out_word_next.status = found ? ffca_pkg::RS_OK : ffca_pkg::RS_ILLEGAL_ERASE;
      end
      default: begin
        out_word_next.status = ffca_pkg::RS_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req_op     <= ffca_pkg::opcode_t'(req_word.opcode);
      req_size   <= req_word.request_size;
      req_handle <= req_word.erase_handle;
    end
    rd_idx <= cnt[IDX_W-1:0];
    if (alloc_step && owner_free) begin
      run_start <= run_begin;
      if (run_fits) begin
        fill_end <= CNT_W'(rd_idx) + CNT_W'(1);
      end
    end
    if (cmd.finish) begin
      out_word <= out_word_next;
    end
  end

  assign rsp_valid = out_valid;
  assign rsp_word  = out_word;

  assign sts.op         = req_op;
  assign sts.clear_done = (wr == CNT_W'(CELLS));
  assign sts.scan_done  = (cnt == lim) && !rd_vld;
  assign sts.found      = found;
  assign sts.fill_done  = (wr == fill_end);
  assign sts.zero_done  = (wr == lim);
  assign sts.alloc_bad  = alloc_bad;
  assign sts.erase_bad  = erase_bad;
  assign sts.out_free   = !out_valid || rsp_ready;

  `FFCA_ASSERT(a_handle_step, !$stable(last_handle) |-> last_handle == HANDLE_BITS'($past(last_handle) + 1'b1), "handle counter skipped")
  `FFCA_ASSERT(a_defrag_order, defrag_move |-> wr <= CNT_W'(rd_idx), "compaction write passed read")

endmodule

@@ src/first_fit_cell_allocator.sv @@
// Channel  Dir  Word                                   Handshake
// req      in   opcode, request_size, erase_handle     valid/ready
// rsp      out  status, new_handle                     valid/ready
// cfg      in   cells_in_use (8 bits)                  write enable, no ready
//
// After reset a clearing pass zeroes every cell, with req held off.
// From accept to result, with one owner read per cycle over the managed cells:
//   alloc scans, then fills the found run; erase or failed alloc ends after the scan;
//   defragment does a read pass, then zero fill of the tail.
// The block returns to idle before the next word is taken.
// One result register: the next request is taken while a result waits on rsp.
module first_fit_cell_allocator #(
  parameter int CELLS       = 128,
  parameter int HANDLE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  ffca_chan_if.sink   req,
  ffca_chan_if.source rsp
);

  ffca_pkg::dp_cmd_t cmd;
  ffca_pkg::dp_sts_t sts;
  logic              in_ready;

  ffca_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ffca_datapath #(
    .CELLS       (CELLS),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req_word  (req.data),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_word  (rsp.data),
    .cmd       (cmd),
    .sts       (sts)
  );

  assign req.ready = in_ready;

endmodule
